// ===== sv/ktz_pkg.sv =====
`timescale 1ns / 1ps
package ktz_pkg;

  localparam int FRAC_BITS = 28;
  localparam int HISTORY_DEPTH = 16;
  localparam int TANH_TABLE_DEPTH = 256;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 31;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_K = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_T = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAMBDA = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_XR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_J = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DPRE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DPOST = 3'd7;

  localparam logic [30:0] GAIN_K_RST = 31'd161061273;
  localparam logic [30:0] INV_T_RST = 31'd766958445;
  localparam logic [28:0] DELTA_RST = 29'd1073742;
  localparam logic [28:0] LAMBDA_RST = 29'd805306;
  localparam logic signed [30:0] XR_RST = -31'sd169651208;
  localparam logic signed [29:0] J_RST = 30'sd0;
  localparam logic [3:0] DPRE_RST = 4'd4;
  localparam logic [3:0] DPOST_RST = 4'd6;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] s2;
    logic signed [31:0] s1;
    logic signed [31:0] lm;
  } nrn_t;

  typedef struct packed {
    logic signed [31:0] e0;
    logic [31:0] d;
    logic [15:0] frac;
    logic neg;
  } lut_t;

  // Restoring fraction num/den with one rounding bit, modulo 2^64 like the spec.
  function automatic logic [63:0] ratio_fixed(logic [63:0] num, logic [63:0] den, int bits);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = num;
    for (int i = 0; i < bits; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    r = r << 1;
    if (r >= den) q = q + 64'd1;
    return q;
  endfunction

  function automatic logic [63:0] mul62(logic [63:0] a, logic [63:0] b);
    logic [127:0] pr;
    pr = {64'd0, a} * {64'd0, b};
    return pr[125:62];
  endfunction

  // exp(-step) as a 62-bit fraction, from the series up to the 30th power.
  function automatic logic [63:0] exp_neg(logic [63:0] step);
    logic [63:0] term;
    logic [63:0] es;
    term = 64'd1 << 62;
    es = 64'd1 << 62;
    for (int n = 1; n <= 30; n++) begin
      term = mul62(term, step) / 64'(n);
      if ((n % 2) == 1) es = es - term;
      else es = es + term;
    end
    return es;
  endfunction

  localparam logic [63:0] X0_MAG =
    ratio_fixed(64'd6971564118917724, 64'd10000000000000000, FRAC_BITS);
  localparam logic [63:0] Z0_MAG =
    ratio_fixed(64'd22748704865822533, 64'd1000000000000000000, FRAC_BITS);
  localparam logic signed [31:0] X0 = -signed'(X0_MAG[31:0]);
  localparam logic signed [31:0] Z0 = -signed'(Z0_MAG[31:0]);

  localparam nrn_t NRN_RST = '{x: X0, y: X0, z: Z0, s2: '0, s1: '0, lm: '0};

  // Product rounded to nearest, ties up.
  function automatic logic signed [39:0] mulr(logic signed [67:0] p);
    logic signed [67:0] t;
    t = p + (68'sd1 <<< (FRAC_BITS - 1));
    return 40'(t >>> FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [39:0] v);
    if (v > 40'sh007FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -40'sh0080000000) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// ===== sv/ktz_hist_mem.sv =====
`timescale 1ns / 1ps
module ktz_hist_mem #(
  parameter int DEPTH = ktz_pkg::HISTORY_DEPTH
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic signed [31:0]       wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic signed [31:0]       rd_data
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/ktz_nrn_mem.sv =====
`timescale 1ns / 1ps
module ktz_nrn_mem (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           clr,
  input  logic           wr_en,
  input  logic           wr_addr,
  input  ktz_pkg::nrn_t  wr_data,
  input  logic           rd_addr,
  output ktz_pkg::nrn_t  rd_data
);

  ktz_pkg::nrn_t mem [2];
  ktz_pkg::nrn_t raw_r;
  logic [1:0] valid_r;
  logic rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    raw_r <= mem[rd_addr];
  end

  // Entries that were never written since reset or restart read as the initial state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= clr ? 1'b0 : valid_r[rd_addr];
      if (clr) begin
        valid_r <= '0;
      end else if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld_r ? raw_r : ktz_pkg::NRN_RST;

endmodule

// ===== sv/ktz_tanh_lut.sv =====
`timescale 1ns / 1ps
module ktz_tanh_lut #(
  parameter int TBL_DEPTH = ktz_pkg::TANH_TABLE_DEPTH
) (
  input  logic signed [39:0] u,
  output ktz_pkg::lut_t      lut
);

  localparam int IW = $clog2(TBL_DEPTH);
  localparam int SH = ktz_pkg::FRAC_BITS + 3;
  localparam logic [63:0] STEP = ((64'd1 << 63) / TBL_DEPTH) << 3;

  typedef logic signed [31:0] tbl_arr_t [TBL_DEPTH];

  function automatic tbl_arr_t build_tbl();
    tbl_arr_t t;
    logic [63:0] one;
    logic [63:0] es;
    logic [63:0] e;
    logic [63:0] q;
    one = 64'd1 << 62;
    es = ktz_pkg::exp_neg(STEP);
    e = one;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      q = ktz_pkg::ratio_fixed(one - e, one + e, ktz_pkg::FRAC_BITS);
      t[i] = (q > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : signed'(q[31:0]);
      e = ktz_pkg::mul62(e, es);
    end
    return t;
  endfunction

  localparam tbl_arr_t TBL = build_tbl();

  logic signed [39:0] mag;
  logic [31:0] a;
  logic [63:0] scaled;
  logic [63:0] idx_full;
  logic [IW-1:0] idx;
  logic [IW-1:0] idx_p1;

  always_comb begin
    mag = u[39] ? -u : u;
    a = (mag > (40'sd1 <<< SH)) ? (32'd1 << SH) : mag[31:0];
    scaled = {32'd0, a} * 64'(TBL_DEPTH);
    idx_full = scaled >> SH;
    idx = idx_full[IW-1:0];
    idx_p1 = idx + 1'b1;
    lut.neg = u[39];
    lut.frac = scaled[SH-1 -: 16];
    if (idx_full >= 64'(TBL_DEPTH - 1)) begin
      lut.e0 = TBL[TBL_DEPTH-1];
      lut.d = '0;
    end else begin
      lut.e0 = TBL[idx];
      lut.d = 32'(TBL[idx_p1] - TBL[idx]);
    end
  end

endmodule

// ===== sv/ktz_neuron_pair_step.sv =====
`timescale 1ns / 1ps
// One item at a time: in_tready is high only in idle, and the next item is taken only
// after the previous result has been loaded for output. The shared 34x34 multiplier runs
// eleven dependent products per tick, and each tick makes a neuron state memory round trip.
// Reset (synchronous, rst_n low) loads default registers and the initial neuron state;
// an item with restart set reloads that state before its own tick.
module ktz_neuron_pair_step #(
  parameter int HISTORY_DEPTH = ktz_pkg::HISTORY_DEPTH,
  parameter int TANH_TABLE_DEPTH = ktz_pkg::TANH_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] stim_current
  input  logic [0:0]  in_tuser,   // [0] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [31:0] tick, [63:32] pre_potential, [95:64] post_potential
  output logic [1:0]  out_tuser,  // [0] pre_spike, [1] post_spike
  input  logic        cfg_wr_en,
  input  logic [ktz_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ktz_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_LOAD0 = 5'd1;
  localparam logic [4:0] S_LOAD1 = 5'd2;
  localparam logic [4:0] S_HIST  = 5'd3;
  localparam logic [4:0] S_JMUL  = 5'd4;
  localparam logic [4:0] S_KY    = 5'd5;
  localparam logic [4:0] S_ARG   = 5'd6;
  localparam logic [4:0] S_ARGM  = 5'd7;
  localparam logic [4:0] S_U     = 5'd8;
  localparam logic [4:0] S_TBL   = 5'd9;
  localparam logic [4:0] S_INT   = 5'd10;
  localparam logic [4:0] S_TANH  = 5'd11;
  localparam logic [4:0] S_DZ    = 5'd12;
  localparam logic [4:0] S_LZ    = 5'd13;
  localparam logic [4:0] S_DONE  = 5'd14;

  logic [30:0] gain_k_r, inv_t_r;
  logic [28:0] delta_r, lambda_r;
  logic signed [30:0] xr_r;
  logic signed [29:0] j_r;
  logic [3:0] dpre_r, dpost_r;

  logic [4:0] state_r, state_nxt;
  logic nk_r;
  logic [31:0] tick_r;
  logic signed [31:0] stim_r;
  logic [AW-1:0] ptr_r;
  ktz_pkg::nrn_t wk_r [2];
  logic [1:0] sp_r;
  logic signed [39:0] iel_r, u_r, dz_r;
  logic signed [31:0] arg_r, xnew_r;
  ktz_pkg::lut_t lut_r, lut_c;
  logic signed [67:0] p_r;
  logic signed [33:0] ma, mb;

  logic [95:0] out_data_r;
  logic [1:0] out_user_r;
  logic out_vld_r;

  logic acc;
  ktz_pkg::nrn_t rd_nrn, upd, wr_nrn, cur;
  logic flag;
  logic nrn_wr;
  logic signed [31:0] hpre_rd, hpost_rd, hp, hq;
  logic [31:0] s_c, m_c;
  logic [AW-1:0] pre_addr, post_addr;
  logic couple_en;
  logic signed [39:0] sum, vv;

  assign acc = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_k_r <= ktz_pkg::GAIN_K_RST;
      inv_t_r <= ktz_pkg::INV_T_RST;
      delta_r <= ktz_pkg::DELTA_RST;
      lambda_r <= ktz_pkg::LAMBDA_RST;
      xr_r <= ktz_pkg::XR_RST;
      j_r <= ktz_pkg::J_RST;
      dpre_r <= ktz_pkg::DPRE_RST;
      dpost_r <= ktz_pkg::DPOST_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ktz_pkg::REG_GAIN_K: gain_k_r <= cfg_wdata[30:0];
        ktz_pkg::REG_INV_T: inv_t_r <= cfg_wdata[30:0];
        ktz_pkg::REG_DELTA: delta_r <= cfg_wdata[28:0];
        ktz_pkg::REG_LAMBDA: lambda_r <= cfg_wdata[28:0];
        ktz_pkg::REG_XR: xr_r <= signed'(cfg_wdata[30:0]);
        ktz_pkg::REG_J: j_r <= signed'(cfg_wdata[29:0]);
        ktz_pkg::REG_DPRE: dpre_r <= cfg_wdata[3:0];
        ktz_pkg::REG_DPOST: dpost_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  ktz_nrn_mem u_nrn_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (acc && in_tuser[0]),
    .wr_en   (nrn_wr),
    .wr_addr (nk_r),
    .wr_data (wr_nrn),
    .rd_addr (state_r == S_LOAD0),
    .rd_data (rd_nrn)
  );

  // Delays past the history saturate to its last entry.
  always_comb begin
    s_c = (32'(dpre_r) > 32'(HISTORY_DEPTH - 1)) ? 32'(HISTORY_DEPTH - 1) : 32'(dpre_r);
    m_c = (32'(dpost_r) > 32'(HISTORY_DEPTH - 1)) ? 32'(HISTORY_DEPTH - 1) : 32'(dpost_r);
    pre_addr = (32'(ptr_r) >= s_c) ? AW'(32'(ptr_r) - s_c)
                                   : AW'(32'(ptr_r) + 32'(HISTORY_DEPTH) - s_c);
    post_addr = (32'(ptr_r) >= m_c) ? AW'(32'(ptr_r) - m_c)
                                    : AW'(32'(ptr_r) + 32'(HISTORY_DEPTH) - m_c);
    couple_en = (tick_r >= s_c) && (tick_r >= m_c);
    // A zero delay bypasses the history memory and uses the value this tick writes.
    hp = (s_c == 32'd0) ? wk_r[0].x : hpre_rd;
    hq = (m_c == 32'd0) ? wk_r[1].x : hpost_rd;
  end

  ktz_hist_mem #(.DEPTH(HISTORY_DEPTH)) u_hist_pre (
    .clk     (clk),
    .wr_en   (state_r == S_LOAD1),
    .wr_addr (ptr_r),
    .wr_data (wk_r[0].x),
    .rd_addr (pre_addr),
    .rd_data (hpre_rd)
  );

  ktz_hist_mem #(.DEPTH(HISTORY_DEPTH)) u_hist_post (
    .clk     (clk),
    .wr_en   (state_r == S_LOAD1),
    .wr_addr (ptr_r),
    .wr_data (rd_nrn.x),
    .rd_addr (post_addr),
    .rd_data (hpost_rd)
  );

  ktz_tanh_lut #(.TBL_DEPTH(TANH_TABLE_DEPTH)) u_tanh (
    .u   (u_r),
    .lut (lut_c)
  );

  // Phase spike check on the freshly read neuron: a strict local maximum above zero after a peak below zero.
  always_comb begin
    logic peak;
    peak = (tick_r >= 32'd2) && (rd_nrn.s2 < rd_nrn.s1) && (rd_nrn.s1 > rd_nrn.x);
    flag = peak && (rd_nrn.s1 > 32'sd0) && (rd_nrn.lm < 32'sd0);
    upd = rd_nrn;
    if (peak) upd.lm = rd_nrn.s1;
    upd.s2 = rd_nrn.s1;
    upd.s1 = rd_nrn.x;
  end

  always_comb begin
    cur = nk_r ? wk_r[1] : wk_r[0];
    sum = 40'(cur.x) - ktz_pkg::mulr(p_r) + 40'(cur.z)
        + (nk_r ? iel_r : 40'(stim_r));
    vv = 40'(lut_r.e0) + 40'(p_r >>> 16);
    wr_nrn = cur;
    wr_nrn.x = xnew_r;
    wr_nrn.y = cur.x;
    wr_nrn.z = ktz_pkg::sat32(40'(cur.z) - dz_r - ktz_pkg::mulr(p_r));
    nrn_wr = (state_r == S_LZ);
  end

  // Shared multiplier operands.
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      S_HIST: begin
        ma = 34'(j_r);
        mb = 34'(hp) - 34'(hq);
      end
      S_KY: begin
        ma = 34'(signed'({1'b0, gain_k_r}));
        mb = 34'(cur.y);
      end
      S_ARGM: begin
        ma = 34'(arg_r);
        mb = 34'(signed'({1'b0, inv_t_r}));
      end
      S_INT: begin
        ma = 34'(signed'({1'b0, lut_r.d}));
        mb = 34'(signed'({1'b0, lut_r.frac}));
      end
      S_TANH: begin
        ma = 34'(signed'({1'b0, delta_r}));
        mb = 34'(cur.z);
      end
      S_DZ: begin
        ma = 34'(signed'({1'b0, lambda_r}));
        mb = 34'(cur.x) - 34'(xr_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    p_r <= 68'(ma) * 68'(mb);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (acc) state_nxt = S_LOAD0;
      S_LOAD0: state_nxt = S_LOAD1;
      S_LOAD1: state_nxt = S_HIST;
      S_HIST: state_nxt = S_JMUL;
      S_JMUL: state_nxt = S_KY;
      S_KY: state_nxt = S_ARG;
      S_ARG: state_nxt = S_ARGM;
      S_ARGM: state_nxt = S_U;
      S_U: state_nxt = S_TBL;
      S_TBL: state_nxt = S_INT;
      S_INT: state_nxt = S_TANH;
      S_TANH: state_nxt = S_DZ;
      S_DZ: state_nxt = S_LZ;
      S_LZ: state_nxt = nk_r ? S_DONE : S_KY;
      S_DONE: if (!out_vld_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      nk_r <= 1'b0;
      tick_r <= '0;
      ptr_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_vld_r && out_tready && (state_r != S_DONE)) out_vld_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          nk_r <= 1'b0;
          if (acc && in_tuser[0]) tick_r <= '0;
        end
        S_LOAD1: ptr_r <= (32'(ptr_r) == 32'(HISTORY_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
        S_LZ: nk_r <= 1'b1;
        S_DONE: begin
          if (!out_vld_r || out_tready) begin
            out_vld_r <= 1'b1;
            if (tick_r != 32'hFFFFFFFF) tick_r <= tick_r + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (acc) stim_r <= signed'(in_tdata);
      S_LOAD0: begin
        wk_r[0] <= upd;
        sp_r[0] <= flag;
      end
      S_LOAD1: begin
        wk_r[1] <= upd;
        sp_r[1] <= flag;
      end
      S_JMUL: iel_r <= couple_en ? ktz_pkg::mulr(p_r) : '0;
      S_ARG: arg_r <= ktz_pkg::sat32(sum);
      S_U: u_r <= ktz_pkg::mulr(p_r);
      S_TBL: lut_r <= lut_c;
      S_TANH: xnew_r <= ktz_pkg::sat32(lut_r.neg ? -vv : vv);
      S_DZ: dz_r <= ktz_pkg::mulr(p_r);
      S_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_data_r <= {wk_r[1].s1, wk_r[0].s1, tick_r};
          out_user_r <= sp_r;
        end
      end
      default: ;
    endcase
  end

  a_restart_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_tuser[0]) |=> (tick_r == 32'd0))
    else $error("tick not cleared by restart");

  a_ptr_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD1) |=> (ptr_r != $past(ptr_r)))
    else $error("history pointer did not advance");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_vld_r && !out_tready) |=> (state_r == S_DONE))
    else $error("result dropped while output stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready)
    else $error("item accepted while busy");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int NUM_PHASES = 8;

  typedef struct packed {
    logic [31:0] tick;
    logic signed [31:0] pre_x;
    logic signed [31:0] post_x;
    logic pre_spike;
    logic post_spike;
  } tick_report_t;

  typedef struct {
    logic signed [31:0] stim;
    bit restart;
    bit typed_head;  // tick index and spike flags are known: 0 and no spikes
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [31:0] in_tdata;
  logic [0:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [95:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_wr_en;
  logic [ktz_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ktz_pkg::CFG_DATA_W-1:0] cfg_wdata;

  always #5 clk = ~clk;

  ktz_neuron_pair_step dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  tick_report_t pending_reports[$];
  int errors = 0;
  int cycles = 0;
  int reports_seen = 0;
  int spikes_seen = 0;
  int restarts_sent = 0;
  bit calm = 1'b0;
  bit hold_off_req = 1'b0;

  // Shadow copy of the neuron pair.
  longint tanh_lut[ktz_pkg::TANH_TABLE_DEPTH];
  longint x_now[2], x_last[2], z_rec[2], two_back[2], one_back[2], last_peak[2];
  longint hist_pre[ktz_pkg::HISTORY_DEPTH], hist_post[ktz_pkg::HISTORY_DEPTH];
  logic [31:0] tick_cnt;
  longint k_gain, t_inv, r_delta, r_lambda, x_rev, j_couple;
  int unsigned lag_pre, lag_post;

  function automatic logic [63:0] frac_div(logic [63:0] num, logic [63:0] den, int bits);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = num;
    for (int i = 0; i < bits; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    r = r << 1;
    if (r >= den) q = q + 64'd1;
    return q;
  endfunction

  function automatic logic [63:0] q62_product(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fix_mul(longint a, longint b);
    longint p;
    p = a * b + (64'sd1 <<< (ktz_pkg::FRAC_BITS - 1));
    return p >>> ktz_pkg::FRAC_BITS;
  endfunction

  function automatic void fill_tanh_lut();
    logic [63:0] unity, stride, term, decay, e;
    unity = 64'd1 << 62;
    stride = ((64'd1 << 63) / ktz_pkg::TANH_TABLE_DEPTH) << 3;
    term = unity;
    decay = unity;
    e = unity;
    for (int n = 1; n <= 30; n++) begin
      term = q62_product(term, stride) / 64'(n);
      if (n % 2 == 1) decay = decay - term;
      else decay = decay + term;
    end
    for (int i = 0; i < ktz_pkg::TANH_TABLE_DEPTH; i++) begin
      tanh_lut[i] = clip32(longint'(frac_div(unity - e, unity + e, ktz_pkg::FRAC_BITS)));
      e = q62_product(e, decay);
    end
  endfunction

  function automatic longint tanh_fix(longint u);
    bit neg;
    longint a, sc, idx, frac, v;
    neg = u < 0;
    a = neg ? -u : u;
    if (a > (64'sd8 <<< ktz_pkg::FRAC_BITS)) a = 64'sd8 <<< ktz_pkg::FRAC_BITS;
    sc = a * ktz_pkg::TANH_TABLE_DEPTH;
    idx = sc >>> (ktz_pkg::FRAC_BITS + 3);
    if (idx >= ktz_pkg::TANH_TABLE_DEPTH - 1) begin
      v = tanh_lut[ktz_pkg::TANH_TABLE_DEPTH-1];
    end else begin
      frac = (sc & ((64'sd1 <<< (ktz_pkg::FRAC_BITS + 3)) - 1))
             >>> (ktz_pkg::FRAC_BITS + 3 - 16);
      v = tanh_lut[idx] + (((tanh_lut[idx+1] - tanh_lut[idx]) * frac) >>> 16);
    end
    return neg ? -v : v;
  endfunction

  function automatic void reload_pair();
    longint x_init, z_init;
    x_init = -longint'(frac_div(64'd6971564118917724, 64'd10000000000000000,
                                ktz_pkg::FRAC_BITS));
    z_init = -longint'(frac_div(64'd22748704865822533, 64'd1000000000000000000,
                                ktz_pkg::FRAC_BITS));
    for (int k = 0; k < 2; k++) begin
      x_now[k] = clip32(x_init);
      x_last[k] = clip32(x_init);
      z_rec[k] = clip32(z_init);
      two_back[k] = 0;
      one_back[k] = 0;
      last_peak[k] = 0;
    end
    for (int k = 0; k < ktz_pkg::HISTORY_DEPTH; k++) begin
      hist_pre[k] = 0;
      hist_post[k] = 0;
    end
    tick_cnt = '0;
  endfunction

  function automatic void step_neuron(int k, longint drive);
    longint x, y, z, arg;
    x = x_now[k];
    y = x_last[k];
    z = z_rec[k];
    arg = clip32(x - fix_mul(k_gain, y) + z + drive);
    x_now[k] = clip32(tanh_fix(fix_mul(arg, t_inv)));
    x_last[k] = x;
    z_rec[k] = clip32(z - fix_mul(r_delta, z) - fix_mul(r_lambda, x - x_rev));
  endfunction

  // A spike is flagged for the previous tick when it was a local peak above zero
  // and the peak before it was below zero.
  function automatic bit peak_spike(int k, longint cur);
    bit flag;
    longint p;
    flag = 1'b0;
    p = one_back[k];
    if (tick_cnt >= 2 && two_back[k] < p && p > cur) begin
      if (p > 0 && last_peak[k] < 0) flag = 1'b1;
      last_peak[k] = p;
    end
    two_back[k] = p;
    one_back[k] = cur;
    return flag;
  endfunction

  function automatic tick_report_t advance_pair(logic signed [31:0] stim, bit restart);
    tick_report_t r;
    longint xa, xb, syn;
    int unsigned s, m;
    if (restart) reload_pair();
    s = (lag_pre > ktz_pkg::HISTORY_DEPTH - 1) ? ktz_pkg::HISTORY_DEPTH - 1 : lag_pre;
    m = (lag_post > ktz_pkg::HISTORY_DEPTH - 1) ? ktz_pkg::HISTORY_DEPTH - 1 : lag_post;
    xa = x_now[0];
    xb = x_now[1];
    for (int k = ktz_pkg::HISTORY_DEPTH - 1; k > 0; k--) begin
      hist_pre[k] = hist_pre[k-1];
      hist_post[k] = hist_post[k-1];
    end
    hist_pre[0] = xa;
    hist_post[0] = xb;
    syn = 0;
    if (tick_cnt >= s && tick_cnt >= m) syn = fix_mul(j_couple, hist_pre[s] - hist_post[m]);
    r.pre_spike = peak_spike(0, xa);
    r.post_spike = peak_spike(1, xb);
    r.tick = tick_cnt;
    r.pre_x = xa[31:0];
    r.post_x = xb[31:0];
    step_neuron(0, longint'(stim));
    step_neuron(1, syn);
    if (tick_cnt != 32'hFFFF_FFFF) tick_cnt = tick_cnt + 1;
    return r;
  endfunction

  function automatic void shadow_reg(logic [ktz_pkg::CFG_IDX_W-1:0] idx, logic [30:0] val);
    case (idx)
      ktz_pkg::REG_GAIN_K: k_gain = longint'(val);
      ktz_pkg::REG_INV_T: t_inv = longint'(val);
      ktz_pkg::REG_DELTA: r_delta = longint'(val[28:0]);
      ktz_pkg::REG_LAMBDA: r_lambda = longint'(val[28:0]);
      ktz_pkg::REG_XR: x_rev = longint'($signed(val));
      ktz_pkg::REG_J: j_couple = longint'($signed(val[29:0]));
      ktz_pkg::REG_DPRE: lag_pre = val[3:0];
      ktz_pkg::REG_DPOST: lag_post = val[3:0];
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic signed [31:0] pick_stim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $signed($urandom_range(0, 1 << 26)) - (1 << 25);
    if (r < 85) return $signed($urandom_range(0, 1 << 29)) - (1 << 28);
    if (r < 95) return $urandom;
    if (r < 97) return 32'sh7FFF_FFFF;
    if (r < 99) return 32'sh8000_0000;
    return 0;
  endfunction

  task automatic send_tick(logic signed [31:0] stim, bit restart, bit typed_head);
    tick_report_t exp_r;
    int g;
    in_tvalid <= 1'b1;
    in_tdata <= stim;
    in_tuser <= restart;
    do @(posedge clk); while (!in_tready);
    exp_r = advance_pair(stim, restart);
    if (typed_head) begin
      exp_r.tick = 32'd0;
      exp_r.pre_spike = 1'b0;
      exp_r.post_spike = 1'b0;
    end
    if (restart) restarts_sent++;
    pending_reports.push_back(exp_r);
    g = pick_gap();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain_reports();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [ktz_pkg::CFG_IDX_W-1:0] idx, logic [30:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    shadow_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic write_all(logic [30:0] gain, logic [30:0] tinv, logic [28:0] dl,
                           logic [28:0] lm, logic [30:0] xr, logic [29:0] jc,
                           logic [3:0] dp, logic [3:0] dq);
    write_reg(ktz_pkg::REG_GAIN_K, gain);
    write_reg(ktz_pkg::REG_INV_T, tinv);
    write_reg(ktz_pkg::REG_DELTA, 31'(dl));
    write_reg(ktz_pkg::REG_LAMBDA, 31'(lm));
    write_reg(ktz_pkg::REG_XR, xr);
    write_reg(ktz_pkg::REG_J, 31'(jc));
    write_reg(ktz_pkg::REG_DPRE, 31'(dp));
    write_reg(ktz_pkg::REG_DPOST, 31'(dq));
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Result checker.
  always @(posedge clk) begin
    tick_report_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.tick = out_tdata[31:0];
      got.pre_x = out_tdata[63:32];
      got.post_x = out_tdata[95:64];
      got.pre_spike = out_tuser[0];
      got.post_spike = out_tuser[1];
      reports_seen++;
      spikes_seen += got.pre_spike + got.post_spike;
      if (pending_reports.size() == 0) begin
        $error("unexpected item on the result channel, tick %0d", got.tick);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        if (got.tick !== want.tick) begin
          $error("tick: expected %0d, got %0d", want.tick, got.tick);
          errors++;
        end
        if (got.pre_x !== want.pre_x) begin
          $error("pre_potential: expected %0d, got %0d", want.pre_x, got.pre_x);
          errors++;
        end
        if (got.post_x !== want.post_x) begin
          $error("post_potential: expected %0d, got %0d", want.post_x, got.post_x);
          errors++;
        end
        if (got.pre_spike !== want.pre_spike) begin
          $error("pre_spike: expected %0b, got %0b", want.pre_spike, got.pre_spike);
          errors++;
        end
        if (got.post_spike !== want.post_spike) begin
          $error("post_spike: expected %0b, got %0b", want.post_spike, got.post_spike);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result receiver with random back-pressure and an occasional long hold-off.
  initial begin
    int g;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      g = pick_gap();
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    fill_tanh_lut();
    k_gain = ktz_pkg::GAIN_K_RST;
    t_inv = ktz_pkg::INV_T_RST;
    r_delta = ktz_pkg::DELTA_RST;
    r_lambda = ktz_pkg::LAMBDA_RST;
    x_rev = ktz_pkg::XR_RST;
    j_couple = ktz_pkg::J_RST;
    lag_pre = ktz_pkg::DPRE_RST;
    lag_post = ktz_pkg::DPOST_RST;
    reload_pair();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: state right after reset, field extremes, restarts mid-run and on
    // back-to-back items, and early ticks where the synapse is still silent.
    rows = '{
      '{32'sd0, 1'b0, 1'b1}, '{32'sh7FFF_FFFF, 1'b0, 1'b0}, '{32'sh8000_0000, 1'b0, 1'b0},
      '{32'sd1, 1'b0, 1'b0}, '{-32'sd1, 1'b0, 1'b0}, '{32'sd0, 1'b1, 1'b1},
      '{32'sd0, 1'b1, 1'b1}, '{32'sd134217728, 1'b0, 1'b0}, '{-32'sd134217728, 1'b0, 1'b0},
      '{32'sh5555_5555, 1'b0, 1'b0}, '{32'shAAAA_AAAA, 1'b0, 1'b0}, '{32'sd0, 1'b0, 1'b0},
      '{32'sd0, 1'b0, 1'b0}, '{32'sd26843545, 1'b0, 1'b0}, '{32'sd0, 1'b0, 1'b0},
      '{32'sh7FFF_FFFF, 1'b1, 1'b1}, '{32'sd0, 1'b0, 1'b0}, '{-32'sd26843545, 1'b0, 1'b0},
      '{32'sd0, 1'b0, 1'b0}, '{32'sd0, 1'b0, 1'b0}
    };
    foreach (rows[i]) send_tick(rows[i].stim, rows[i].restart, rows[i].typed_head);
    drain_reports();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: write_all(31'd161061273, 31'd766958445, 29'd1073742, 29'd805306,
                     31'h75E2_48F8, 30'd26843546, 4'd0, 4'd0);
        1: write_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, 29'h1000_0000, 29'h1000_0000,
                     31'h2000_0000, 30'h1000_0000, 4'd15, 4'd15);
        2: write_all(31'd0, 31'd0, 29'd0, 29'd0, 31'h6000_0000, 30'h3000_0000, 4'd0, 4'd15);
        3: write_all(31'd161061273, 31'd766958445, 29'd1073742, 29'd805306,
                     31'h75E2_48F8, 30'h3E66_6666, 4'd15, 4'd0);
        default: begin
          if ($urandom_range(0, 1)) begin
            write_all(31'($urandom_range(120000000, 200000000)),
                      31'($urandom_range(600000000, 900000000)),
                      29'($urandom_range(0, 4000000)), 29'($urandom_range(0, 4000000)),
                      31'($signed($urandom_range(0, 1 << 28)) - (1 << 28)),
                      30'($signed($urandom_range(0, 1 << 29)) - (1 << 28)),
                      4'($urandom), 4'($urandom));
          end else begin
            write_all(31'($urandom), 31'($urandom), 29'($urandom_range(0, 1 << 28)),
                      29'($urandom_range(0, 1 << 28)),
                      31'($signed($urandom_range(0, 1 << 30)) - (1 << 29)),
                      30'($signed($urandom_range(0, 1 << 29)) - (1 << 28)),
                      4'($urandom), 4'($urandom));
          end
        end
      endcase
      calm = (ph % 3 == 1);
      if (ph == 1 || ph == 5) hold_off_req = 1'b1;
      send_tick(pick_stim(), 1'b1, 1'b1);
      for (int i = 1; i < ITEMS_PER_PHASE; i++) begin
        send_tick(pick_stim(), $urandom_range(0, 99) == 0, 1'b0);
      end
      calm = 1'b0;
      drain_reports();
    end

    if (pending_reports.size() != 0) begin
      $error("%0d expected items never arrived", pending_reports.size());
      errors++;
    end
    $display("Ran %0d ticks over %0d register settings with %0d restarts.",
             reports_seen, NUM_PHASES + 1, restarts_sent);
    $display("Saw %0d spike flags; %0d mismatches.", spikes_seen, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ktz_pkg.sv
sv/ktz_hist_mem.sv
sv/ktz_nrn_mem.sv
sv/ktz_tanh_lut.sv
sv/ktz_neuron_pair_step.sv
dv/tb_top.sv
